// File: rtl/ubxfp_pkg.sv
// ----------------------------------------------------------------------------
// ubxfp_pkg
// Shared types and constants for the UBX frame parser: phase codes, event
// codes, sync bytes and the reset value of the payload length limit.
// ----------------------------------------------------------------------------
package ubxfp_pkg;

   localparam logic [7:0]  SYNC_FIRST      = 8'hB5;
   localparam logic [7:0]  SYNC_SECOND     = 8'h62;
   localparam logic [15:0] LIMIT_RESET     = 16'd1024;

   localparam logic [2:0]  EV_NONE         = 3'd0;
   localparam logic [2:0]  EV_PAYLOAD      = 3'd1;
   localparam logic [2:0]  EV_GOOD         = 3'd2;
   localparam logic [2:0]  EV_BAD          = 3'd3;
   localparam logic [2:0]  EV_OVERSIZE     = 3'd4;

   // header byte positions
   localparam logic [15:0] HDR_CLASS       = 16'd0;
   localparam logic [15:0] HDR_IDENT       = 16'd1;
   localparam logic [15:0] HDR_LEN_LO      = 16'd2;

   typedef enum logic [5:0] {
      PH_HUNT    = 6'b000001,
      PH_SYNC2   = 6'b000010,
      PH_HEADER  = 6'b000100,
      PH_PAYLOAD = 6'b001000,
      PH_CHECK_A = 6'b010000,
      PH_CHECK_B = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [7:0]  payload_value;
      logic [15:0] payload_index;
      logic [7:0]  message_class;
      logic [7:0]  message_identifier;
      logic [15:0] payload_length;
      logic [31:0] good_frame_count;
      logic [31:0] bad_checksum_count;
      logic [31:0] oversized_count;
   } result_type;

endpackage

// File: rtl/ubxfp_if.sv
// ----------------------------------------------------------------------------
// ubxfp channel interfaces
// Valid/ready channels for the received byte stream, the parser results and
// the limit register write port.
// ----------------------------------------------------------------------------
interface ubxfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface ubxfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_res;
   logic [7:0]  payload_value;
   logic [15:0] payload_index;
   logic [7:0]  message_class;
   logic [7:0]  message_identifier;
   logic [15:0] payload_length;
   logic [31:0] good_frame_count;
   logic [31:0] bad_checksum_count;
   logic [31:0] oversized_count;

   modport source (output valid, output event_res, output payload_value,
                   output payload_index, output message_class,
                   output message_identifier, output payload_length,
                   output good_frame_count, output bad_checksum_count,
                   output oversized_count, input ready);
   modport sink   (input valid, input event_res, input payload_value,
                   input payload_index, input message_class,
                   input message_identifier, input payload_length,
                   input good_frame_count, input bad_checksum_count,
                   input oversized_count, output ready);
endinterface

interface ubxfp_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/ubx_frame_parser.sv
// ----------------------------------------------------------------------------
// ubx_frame_parser
// Byte-serial UBX frame parser with Fletcher-8 check and outcome counters.
// ----------------------------------------------------------------------------
// Every byte transfer loads its result into the output register.
// Throughput: one byte per cycle if not stalled; the phase, checksum and
// counter update for a byte is one pass of logic into the result register.
// A new byte is taken whenever the result register is empty or being drained.
// Reset (synchronous, active high): hunting for sync, all state and counters
// cleared, limit back to 1024, result register empty.
// ----------------------------------------------------------------------------
module ubx_frame_parser (
   input  logic        clock,
   input  logic        reset,
   ubxfp_req_if.sink   req_chan,
   ubxfp_rsp_if.source rsp_chan,
   ubxfp_csr_if.sink   csr_chan
);

   ubxfp_pkg::phase_type  phase_ff, phase_in;
   logic [7:0]            class_ff, class_in;
   logic [7:0]            ident_ff, ident_in;
   logic [15:0]           length_ff, length_in;
   logic [15:0]           count_ff, count_in;
   logic [7:0]            sum_a_ff, sum_a_in;
   logic [7:0]            sum_b_ff, sum_b_in;
   logic [7:0]            check_a_ff, check_a_in;
   logic [31:0]           good_ff, good_in;
   logic [31:0]           bad_ff, bad_in;
   logic [31:0]           over_ff, over_in;
   logic [15:0]           limit_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   ubxfp_pkg::result_type result_ff, result_in;

   logic                  req_xfer;
   logic [7:0]            b;
   logic [7:0]            add_a;
   logic [7:0]            add_b;
   logic [15:0]           len_full;
   logic [15:0]           count_inc;
   logic [2:0]            ev;
   logic [7:0]            pval;
   logic [15:0]           pidx;
   ubxfp_pkg::phase_type  resync_phase;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign b            = req_chan.data_byte;
   assign add_a        = sum_a_ff + b;
   assign add_b        = sum_b_ff + add_a;
   assign len_full     = {b, length_ff[7:0]};
   assign count_inc    = count_ff + 16'd1;
   assign resync_phase = (b == ubxfp_pkg::SYNC_FIRST) ? ubxfp_pkg::PH_SYNC2
                                                      : ubxfp_pkg::PH_HUNT;

   always_comb begin
      phase_in   = phase_ff;
      class_in   = class_ff;
      ident_in   = ident_ff;
      length_in  = length_ff;
      count_in   = count_ff;
      sum_a_in   = sum_a_ff;
      sum_b_in   = sum_b_ff;
      check_a_in = check_a_ff;
      good_in    = good_ff;
      bad_in     = bad_ff;
      over_in    = over_ff;
      ev         = ubxfp_pkg::EV_NONE;
      pval       = 8'd0;
      pidx       = 16'd0;

      case (phase_ff)
         ubxfp_pkg::PH_HUNT: begin
            if (b == ubxfp_pkg::SYNC_FIRST) begin
               phase_in = ubxfp_pkg::PH_SYNC2;
            end
         end
         ubxfp_pkg::PH_SYNC2: begin
            if (b == ubxfp_pkg::SYNC_SECOND) begin
               phase_in = ubxfp_pkg::PH_HEADER;
               count_in = 16'd0;
               sum_a_in = 8'd0;
               sum_b_in = 8'd0;
            end else begin
               phase_in = resync_phase;
            end
         end
         ubxfp_pkg::PH_HEADER: begin
            sum_a_in = add_a;
            sum_b_in = add_b;
            count_in = count_inc;
            if (count_ff == ubxfp_pkg::HDR_CLASS) begin
               class_in = b;
            end else if (count_ff == ubxfp_pkg::HDR_IDENT) begin
               ident_in = b;
            end else if (count_ff == ubxfp_pkg::HDR_LEN_LO) begin
               length_in = {8'd0, b};
            end else begin
               length_in = len_full;
               count_in  = 16'd0;
               if (len_full > limit_ff) begin
                  over_in  = over_ff + 32'd1;
                  ev       = ubxfp_pkg::EV_OVERSIZE;
                  phase_in = resync_phase;
               end else if (len_full == 16'd0) begin
                  phase_in = ubxfp_pkg::PH_CHECK_A;
               end else begin
                  phase_in = ubxfp_pkg::PH_PAYLOAD;
               end
            end
         end
         ubxfp_pkg::PH_PAYLOAD: begin
            sum_a_in = add_a;
            sum_b_in = add_b;
            ev       = ubxfp_pkg::EV_PAYLOAD;
            pval     = b;
            pidx     = count_ff;
            count_in = count_inc;
            if (count_inc >= length_ff) begin
               phase_in = ubxfp_pkg::PH_CHECK_A;
            end
         end
         ubxfp_pkg::PH_CHECK_A: begin
            check_a_in = b;
            phase_in   = ubxfp_pkg::PH_CHECK_B;
         end
         ubxfp_pkg::PH_CHECK_B: begin
            if (check_a_ff == sum_a_ff && b == sum_b_ff) begin
               good_in  = good_ff + 32'd1;
               ev       = ubxfp_pkg::EV_GOOD;
               phase_in = ubxfp_pkg::PH_HUNT;
            end else begin
               bad_in   = bad_ff + 32'd1;
               ev       = ubxfp_pkg::EV_BAD;
               phase_in = resync_phase;
            end
         end
         default: begin
            phase_in = ubxfp_pkg::PH_HUNT;
         end
      endcase
   end

   always_comb begin
      result_in.event_res          = ev;
      result_in.payload_value      = pval;
      result_in.payload_index      = pidx;
      result_in.message_class      = class_in;
      result_in.message_identifier = ident_in;
      result_in.payload_length     = length_in;
      result_in.good_frame_count   = good_in;
      result_in.bad_checksum_count = bad_in;
      result_in.oversized_count    = over_in;
   end

   // hold the result until the sink takes it
   assign rsp_valid_in = req_xfer || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ubxfp_pkg::PH_HUNT;
         class_ff     <= 8'd0;
         ident_ff     <= 8'd0;
         length_ff    <= 16'd0;
         count_ff     <= 16'd0;
         sum_a_ff     <= 8'd0;
         sum_b_ff     <= 8'd0;
         check_a_ff   <= 8'd0;
         good_ff      <= 32'd0;
         bad_ff       <= 32'd0;
         over_ff      <= 32'd0;
         limit_ff     <= ubxfp_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid) begin
            limit_ff <= csr_chan.data;
         end
         if (req_xfer) begin
            phase_ff   <= phase_in;
            class_ff   <= class_in;
            ident_ff   <= ident_in;
            length_ff  <= length_in;
            count_ff   <= count_in;
            sum_a_ff   <= sum_a_in;
            sum_b_ff   <= sum_b_in;
            check_a_ff <= check_a_in;
            good_ff    <= good_in;
            bad_ff     <= bad_in;
            over_ff    <= over_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         result_ff <= result_in;
      end
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.event_res          = result_ff.event_res;
   assign rsp_chan.payload_value      = result_ff.payload_value;
   assign rsp_chan.payload_index      = result_ff.payload_index;
   assign rsp_chan.message_class      = result_ff.message_class;
   assign rsp_chan.message_identifier = result_ff.message_identifier;
   assign rsp_chan.payload_length     = result_ff.payload_length;
   assign rsp_chan.good_frame_count   = result_ff.good_frame_count;
   assign rsp_chan.bad_checksum_count = result_ff.bad_checksum_count;
   assign rsp_chan.oversized_count    = result_ff.oversized_count;

endmodule

// File: rtl/ubxfp_checker.sv
// ----------------------------------------------------------------------------
// ubxfp_checker
// Port-level checks on the UBX frame parser, attached by bind.
// ----------------------------------------------------------------------------
module ubxfp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  event_res,
   input logic [7:0]  payload_value,
   input logic [15:0] payload_index,
   input logic [15:0] payload_length
);

   // every byte transfer yields a result in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("no result after byte transfer");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(event_res)
                                 && $stable(payload_index))
      else $error("stalled result changed");

   // forwarded bytes lie inside the declared payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && event_res == ubxfp_pkg::EV_PAYLOAD |->
         payload_index < payload_length)
      else $error("payload index beyond declared length");

   // payload fields are zero unless a byte is forwarded
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && event_res != ubxfp_pkg::EV_PAYLOAD |->
         payload_value == 8'd0 && payload_index == 16'd0)
      else $error("payload fields set without payload event");

endmodule

bind ubx_frame_parser ubxfp_checker u_ubxfp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .event_res      (rsp_chan.event_res),
   .payload_value  (rsp_chan.payload_value),
   .payload_index  (rsp_chan.payload_index),
   .payload_length (rsp_chan.payload_length)
);
